// ----- rtl/ifmt_pkg.sv -----
// Types, codes and character helpers shared by the integer field formatter.
`default_nettype none

package ifmt_pkg;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] value;
        logic               value_wide;
        logic [5:0]         field_width;
        logic [5:0]         precision;
        logic               left_justify;
        logic               zero_fill;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } result_t;

    // Conversion kinds
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_SDEC = 3'd1;
    localparam logic [2:0] KIND_UDEC = 3'd2;
    localparam logic [2:0] KIND_HEXL = 3'd3;
    localparam logic [2:0] KIND_HEXU = 3'd4;
    localparam logic [2:0] KIND_OCT  = 3'd5;
    localparam logic [2:0] KIND_PTR  = 3'd6;
    localparam logic [2:0] KIND_NONE = 3'd7;

    // Digit register: 24 nibbles covers 20 decimal, 16 hex and 22 octal digits
    localparam int DIG_COUNT = 24;
    localparam int DIG_BITS  = 4 * DIG_COUNT;

    // Digit unit operations
    typedef logic [2:0] conv_op_t;
    localparam conv_op_t OP_HOLD     = 3'd0;
    localparam conv_op_t OP_LOAD_DEC = 3'd1;
    localparam conv_op_t OP_LOAD_HEX = 3'd2;
    localparam conv_op_t OP_LOAD_OCT = 3'd3;
    localparam conv_op_t OP_DABBLE   = 3'd4;
    localparam conv_op_t OP_SHIFT    = 3'd5;

    typedef struct packed {
        conv_op_t    op;
        logic [63:0] val;
    } conv_ctrl_t;

    // ASCII
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_X       = 8'h78;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (nib < 4'd10)
        begin
            digit_char = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            digit_char = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ifmt_conv.sv -----
// Digit register with shift-add-3 binary-to-BCD step and nibble shift-out.
`default_nettype none

module ifmt_conv (
    input  wire logic                clk,
    input  wire ifmt_pkg::conv_ctrl_t ctrl,
    output logic [3:0]               top
);

    logic [ifmt_pkg::DIG_BITS-1:0] dig_reg;
    logic [ifmt_pkg::DIG_BITS-1:0] dig_next;
    logic [63:0]                   mag_reg;
    logic [63:0]                   mag_next;
    logic [ifmt_pkg::DIG_BITS-1:0] adj;
    logic [ifmt_pkg::DIG_BITS-1:0] oct;

    // Add 3 to every BCD digit of 5 or more before the next doubling
    always_comb
    begin
        for (int i = 0; i < ifmt_pkg::DIG_COUNT; i++)
        begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                        : dig_reg[4*i +: 4];
        end
    end

    // Spread 3-bit octal groups one per nibble
    always_comb
    begin
        oct = '0;
        for (int i = 0; i < ifmt_pkg::DIG_COUNT; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (3 * i + j < 64)
                begin
                    oct[4*i + j] = ctrl.val[3*i + j];
                end
            end
        end
    end

    always_comb
    begin
        dig_next = dig_reg;
        mag_next = mag_reg;
        unique case (ctrl.op)
            ifmt_pkg::OP_HOLD:
            begin
            end
            ifmt_pkg::OP_LOAD_DEC:
            begin
                dig_next = '0;
                mag_next = ctrl.val;
            end
            ifmt_pkg::OP_LOAD_HEX:
            begin
                dig_next = {{(ifmt_pkg::DIG_BITS-64){1'b0}}, ctrl.val};
            end
            ifmt_pkg::OP_LOAD_OCT:
            begin
                dig_next = oct;
            end
            ifmt_pkg::OP_DABBLE:
            begin
                dig_next = {adj[ifmt_pkg::DIG_BITS-2:0], mag_reg[63]};
                mag_next = {mag_reg[62:0], 1'b0};
            end
            ifmt_pkg::OP_SHIFT:
            begin
                dig_next = {dig_reg[ifmt_pkg::DIG_BITS-5:0], 4'd0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        mag_reg <= mag_next;
    end

    assign top = dig_reg[ifmt_pkg::DIG_BITS-1 -: 4];

endmodule

`default_nettype wire

// ----- rtl/integer_field_formatter.sv -----
// Top level of the integer field formatter: sequencer, padding and character output.
//
//  Channel | Ports                   | Handshake
//  --------+-------------------------+---------------------------------------------
//  in      | start, busy, item       | item taken at a clock edge with start & !busy & kind != NONE
//  out     | strobe, result          | one char per cycle with strobe, never stalled
//
// Sequence: the item is taken in S_IDLE; decimal kinds then run 64 shift-add-3 steps
// through the shared digit register; every kind then strips up to 23 leading zero
// nibbles (one nibble per cycle), then emits one character per cycle (up to 49).
// Reset clears the sequencer and the strobe; the digit register needs no reset.
// busy stays high from the item until its last character is registered, and is low in
// the cycle that carries it; the receiver cannot stall, so the output never holds the sequencer.
`default_nettype none

module integer_field_formatter #(
    parameter int POINTER_DIGITS = 16,
    parameter int MAX_WIDTH      = 48
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ifmt_pkg::item_t   item,
    output logic                   strobe,
    output ifmt_pkg::result_t      result
);

    localparam logic [5:0] MaxW = 6'(MAX_WIDTH);
    localparam logic [5:0] PtrW = 6'(POINTER_DIGITS);
    localparam logic [4:0] DigN = 5'(ifmt_pkg::DIG_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_LPAD = 3'd4;
    localparam logic [2:0] S_DIG  = 3'd5;
    localparam logic [2:0] S_RPAD = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       strobe_reg, strobe_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [4:0] nd_reg, nd_next;
    logic [5:0] pad_reg, pad_next;
    logic       pre_cnt_reg, pre_cnt_next;

    logic [2:0] kind_reg, kind_next;
    logic       neg_reg, neg_next;
    logic [5:0] width_reg, width_next;
    logic       zfill_reg, zfill_next;
    logic       ljust_reg, ljust_next;
    logic       upper_reg, upper_next;
    logic [7:0] char_reg, char_next;
    ifmt_pkg::result_t result_reg, result_next;

    ifmt_pkg::conv_ctrl_t ctrl;
    logic [3:0]           top;

    logic [63:0] uval;
    logic [63:0] sval;
    logic [63:0] mag;
    logic        neg;
    logic [5:0]  w_sat;
    logic [5:0]  p_sat;
    logic        is_ptr;
    logic        has_prefix;

    ifmt_conv u_conv (
        .clk  (clk),
        .ctrl (ctrl),
        .top  (top)
    );

    assign busy = (state_reg != S_IDLE);

    // Operand preparation at accept time
    assign uval  = item.value_wide ? 64'(item.value) : {32'd0, item.value[31:0]};
    assign sval  = item.value_wide ? 64'(item.value)
                                   : {{32{item.value[31]}}, item.value[31:0]};
    assign neg   = sval[63];
    assign mag   = neg ? (64'd0 - sval) : sval;
    assign w_sat = (item.field_width > MaxW) ? MaxW : item.field_width;
    assign p_sat = (item.precision > MaxW) ? MaxW : item.precision;

    assign is_ptr     = (kind_reg == ifmt_pkg::KIND_PTR);
    assign has_prefix = neg_reg || is_ptr;

    always_comb
    begin
        state_next   = state_reg;
        strobe_next  = 1'b0;
        cnt_next     = cnt_reg;
        nd_next      = nd_reg;
        pad_next     = pad_reg;
        pre_cnt_next = pre_cnt_reg;
        kind_next    = kind_reg;
        neg_next     = neg_reg;
        width_next   = width_reg;
        zfill_next   = zfill_reg;
        ljust_next   = ljust_reg;
        upper_next   = upper_reg;
        char_next    = char_reg;
        result_next  = result_reg;
        ctrl.op      = ifmt_pkg::OP_HOLD;
        ctrl.val     = uval;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && item.kind != ifmt_pkg::KIND_NONE)
                begin
                    kind_next    = item.kind;
                    neg_next     = 1'b0;
                    width_next   = w_sat;
                    zfill_next   = item.zero_fill;
                    ljust_next   = item.left_justify;
                    upper_next   = (item.kind == ifmt_pkg::KIND_HEXU);
                    char_next    = item.value[7:0];
                    cnt_next     = '0;
                    nd_next      = DigN;
                    pre_cnt_next = 1'b0;
                    state_next   = S_SCAN;
                    case (item.kind) inside
                        ifmt_pkg::KIND_SDEC, ifmt_pkg::KIND_UDEC:
                        begin
                            ctrl.op    = ifmt_pkg::OP_LOAD_DEC;
                            state_next = S_CONV;
                            if (item.kind == ifmt_pkg::KIND_SDEC)
                            begin
                                ctrl.val = mag;
                                neg_next = neg;
                            end
                            // a nonzero precision overrides width and forces zero fill
                            if (p_sat != 6'd0)
                            begin
                                width_next = p_sat;
                                zfill_next = 1'b1;
                            end
                        end
                        ifmt_pkg::KIND_HEXL, ifmt_pkg::KIND_HEXU:
                        begin
                            ctrl.op = ifmt_pkg::OP_LOAD_HEX;
                        end
                        ifmt_pkg::KIND_OCT:
                        begin
                            ctrl.op = ifmt_pkg::OP_LOAD_OCT;
                        end
                        ifmt_pkg::KIND_PTR:
                        begin
                            ctrl.op    = ifmt_pkg::OP_LOAD_HEX;
                            width_next = PtrW;
                            zfill_next = 1'b1;
                            ljust_next = 1'b0;
                        end
                        default:
                        begin
                            // char: single digit, scan ends at once
                            nd_next = 5'd1;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                ctrl.op  = ifmt_pkg::OP_DABBLE;
                cnt_next = cnt_reg + 6'd1;
                if (&cnt_reg)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (top != 4'd0 || nd_reg == 5'd1)
                begin
                    pad_next = (width_reg > {1'b0, nd_reg}) ? width_reg - {1'b0, nd_reg}
                                                            : 6'd0;
                    if (has_prefix)
                    begin
                        state_next = S_PRE;
                    end
                    else if (!ljust_reg && pad_next != 6'd0)
                    begin
                        state_next = S_LPAD;
                    end
                    else
                    begin
                        state_next = S_DIG;
                    end
                end
                else
                begin
                    // drop a leading zero nibble
                    ctrl.op = ifmt_pkg::OP_SHIFT;
                    nd_next = nd_reg - 5'd1;
                end
            end
            S_PRE:
            begin
                strobe_next           = 1'b1;
                result_next.last_char = 1'b0;
                if (is_ptr && !pre_cnt_reg)
                begin
                    result_next.out_char = ifmt_pkg::CH_ZERO;
                    pre_cnt_next         = 1'b1;
                end
                else
                begin
                    result_next.out_char = is_ptr ? ifmt_pkg::CH_X : ifmt_pkg::CH_MINUS;
                    if (!ljust_reg && pad_reg != 6'd0)
                    begin
                        state_next = S_LPAD;
                    end
                    else
                    begin
                        state_next = S_DIG;
                    end
                end
            end
            S_LPAD:
            begin
                strobe_next           = 1'b1;
                result_next.out_char  = zfill_reg ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
                result_next.last_char = 1'b0;
                pad_next              = pad_reg - 6'd1;
                if (pad_reg == 6'd1)
                begin
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                strobe_next           = 1'b1;
                result_next.out_char  = (kind_reg == ifmt_pkg::KIND_CHAR)
                                      ? char_reg : ifmt_pkg::digit_char(top, upper_reg);
                result_next.last_char = 1'b0;
                ctrl.op               = ifmt_pkg::OP_SHIFT;
                nd_next               = nd_reg - 5'd1;
                if (nd_reg == 5'd1)
                begin
                    if (ljust_reg && pad_reg != 6'd0)
                    begin
                        state_next = S_RPAD;
                    end
                    else
                    begin
                        result_next.last_char = 1'b1;
                        state_next            = S_IDLE;
                    end
                end
            end
            S_RPAD:
            begin
                strobe_next           = 1'b1;
                result_next.out_char  = ifmt_pkg::CH_SPACE;
                result_next.last_char = 1'b0;
                pad_next              = pad_reg - 6'd1;
                if (pad_reg == 6'd1)
                begin
                    result_next.last_char = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            strobe_reg  <= 1'b0;
            cnt_reg     <= '0;
            nd_reg      <= '0;
            pad_reg     <= '0;
            pre_cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            cnt_reg     <= cnt_next;
            nd_reg      <= nd_next;
            pad_reg     <= pad_next;
            pre_cnt_reg <= pre_cnt_next;
        end
    end

    // Item fields and output character
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        neg_reg    <= neg_next;
        width_reg  <= width_next;
        zfill_reg  <= zfill_next;
        ljust_reg  <= ljust_next;
        upper_reg  <= upper_next;
        char_reg   <= char_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // A character only follows a cycle in which the sequencer was working
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character emitted without an item in progress");

    // The final character leaves with the sequencer already free
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_char) |-> !busy)
        else $error("busy still high on final character");

    // No character directly after the final one of a field
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_char) |=> !strobe)
        else $error("character right after end of field");

    // A valid kind always occupies the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind != ifmt_pkg::KIND_NONE) |=> busy)
        else $error("accepted item did not start the sequencer");

endmodule

`default_nettype wire
